>>> hw/rtl/kmrb_pkg.sv
// shared types, constants and character map for the key matrix repeat buffer
package kmrb_pkg;

	// sizes
	localparam int NUM_KEYS   = 56;
	localparam int FIFO_DEPTH = 16;
	localparam int KEY_W      = $clog2(NUM_KEYS);
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int TABLE_KEYS = 56;

	// key codes with a special role
	localparam logic [5:0] CODE_CTRL  = 6'd3;
	localparam logic [5:0] CODE_SHIFT = 6'd5;
	localparam logic [5:0] CODE_SPACE = 6'd6;

	// character adjustments
	localparam logic [6:0] CTRL_MASK   = 7'h1f;
	localparam logic [6:0] CASE_OFFSET = 7'h20;
	localparam logic [6:0] CHAR_LOW_A  = 7'h61;
	localparam logic [6:0] CHAR_LOW_Z  = 7'h7a;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_DELAY = 2'd0,
		CFG_NEXT_DELAY  = 2'd1,
		CFG_REL_HOLD    = 2'd2
	} cfg_idx_t;

	localparam logic [7:0] FIRST_DELAY_RST = 8'd200;
	localparam logic [7:0] NEXT_DELAY_RST  = 8'd50;
	localparam logic [7:0] REL_HOLD_RST    = 8'd25;

	// request modes
	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_READ   = 2'd1,
		MODE_FLUSH  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] key_index;
		logic       pressed;
		logic [7:0] elapsed;
	} cmd_t;

	typedef struct packed {
		logic       key_valid;
		logic [5:0] key_code;
		logic [6:0] ascii_char;
		logic       caps_lock;
		logic       insert_mode;
	} res_t;

	// counter memory write and read
	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] idx;
		logic [7:0]       prs;
		logic [7:0]       rel;
	} cnt_wr_t;

	typedef struct packed {
		logic [7:0] prs;
		logic [7:0] rel;
	} cnt_rd_t;

	typedef struct packed {
		logic shift;
		logic ctrl;
	} mod_held_t;

	localparam logic [6:0] MAP_PLAIN [TABLE_KEYS] = '{
		7'h32, 7'h31, 7'h00, 7'h73, 7'h00, 7'h20, 7'h09, 7'h71, 7'h33, 7'h78,
		7'h65, 7'h61, 7'h7a, 7'h77, 7'h34, 7'h35, 7'h76, 7'h66, 7'h64, 7'h63,
		7'h72, 7'h36, 7'h37, 7'h6e, 7'h74, 7'h67, 7'h62, 7'h79, 7'h39, 7'h38,
		7'h68, 7'h75, 7'h6a, 7'h6d, 7'h69, 7'h5c, 7'h3d, 7'h1e, 7'h6c, 7'h3b,
		7'h1f, 7'h5b, 7'h2d, 7'h30, 7'h2c, 7'h6f, 7'h6b, 7'h2e, 7'h70, 7'h5d,
		7'h08, 7'h1d, 7'h2f, 7'h0d, 7'h1c, 7'h27
	};

	localparam logic [6:0] MAP_SHIFT [TABLE_KEYS] = '{
		7'h40, 7'h21, 7'h00, 7'h73, 7'h00, 7'h14, 7'h09, 7'h71, 7'h23, 7'h78,
		7'h65, 7'h61, 7'h7a, 7'h77, 7'h24, 7'h25, 7'h76, 7'h66, 7'h64, 7'h63,
		7'h72, 7'h5e, 7'h26, 7'h6e, 7'h74, 7'h67, 7'h62, 7'h79, 7'h28, 7'h2a,
		7'h68, 7'h75, 7'h6a, 7'h6d, 7'h69, 7'h7c, 7'h2b, 7'h15, 7'h6c, 7'h3a,
		7'h0c, 7'h7b, 7'h5f, 7'h29, 7'h3c, 7'h6f, 7'h6b, 7'h3e, 7'h70, 7'h7d,
		7'h7f, 7'h0b, 7'h3f, 7'h1b, 7'h04, 7'h22
	};

	// map a key code to a character under the current modifier state
	function automatic logic [6:0] kmrb_ascii(input logic [5:0] code, input logic shift,
			input logic ctrl, input logic caps);
		logic [5:0] idx;
		logic [6:0] ch;
		logic       up;
		logic       letter;
		idx    = code - 6'd1;
		ch     = shift ? MAP_SHIFT[idx] : MAP_PLAIN[idx];
		letter = (ch >= CHAR_LOW_A) && (ch <= CHAR_LOW_Z);
		up     = shift ^ caps;
		if (code == 6'd0 || {1'b0, code} > 7'(NUM_KEYS) || {1'b0, code} > 7'(TABLE_KEYS)) begin
			return 7'd0;
		end
		if (ch == 7'd0) begin
			return 7'd0;
		end
		if (ctrl && letter) begin
			return ch & CTRL_MASK;
		end
		if (up && letter) begin
			return ch - CASE_OFFSET;
		end
		return ch;
	endfunction

endpackage

>>> hw/rtl/kmrb_count_mem.sv
// per-key press and release counter memory with bypass of the latest write
module kmrb_count_mem
	import kmrb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [KEY_W-1:0] rd_idx,
	input  cnt_wr_t          wr,
	output cnt_rd_t          cnt,
	output mod_held_t        held
);

	logic [15:0]         cnt_mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] vld_q;
	logic [15:0]         rd_data_q;
	logic                rd_vld_q;
	logic [KEY_W-1:0]    rd_idx_q;
	logic                fwd_vld_q;
	logic [KEY_W-1:0]    fwd_idx_q;
	logic [15:0]         fwd_data_q;
	logic                shift_nz_q;
	logic                ctrl_nz_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			cnt_mem[wr.idx] <= {wr.prs, wr.rel};
		end
		if (rd_en) begin
			rd_data_q <= cnt_mem[rd_idx];
		end
	end

	// written flags, read index, latest write for bypass and modifier held flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
			rd_idx_q   <= '0;
			fwd_vld_q  <= 1'b0;
			fwd_idx_q  <= '0;
			fwd_data_q <= '0;
			shift_nz_q <= 1'b0;
			ctrl_nz_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
				rd_idx_q <= rd_idx;
			end
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
				fwd_vld_q     <= 1'b1;
				fwd_idx_q     <= wr.idx;
				fwd_data_q    <= {wr.prs, wr.rel};
				if (7'(wr.idx) == 7'(CODE_SHIFT - 6'd1)) begin
					shift_nz_q <= (wr.prs != 8'd0);
				end
				if (7'(wr.idx) == 7'(CODE_CTRL - 6'd1)) begin
					ctrl_nz_q <= (wr.prs != 8'd0);
				end
			end
		end
	end

	// newest value wins, unwritten entries read as zero
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == rd_idx_q) begin
			{cnt.prs, cnt.rel} = fwd_data_q;
		end else if (rd_vld_q) begin
			{cnt.prs, cnt.rel} = rd_data_q;
		end else begin
			{cnt.prs, cnt.rel} = 16'd0;
		end
	end

	assign held.shift = shift_nz_q;
	assign held.ctrl  = ctrl_nz_q;

endmodule

>>> hw/rtl/key_matrix_repeat_buffer_top.sv
// top level of the key matrix scanner with typematic repeat and key buffer
//
// Takes one request per cycle and returns one result per request. The request
// and its counter memory read are registered at acceptance, and the result
// register loads when the input stage advances. Requests stall only while a
// result waits under back pressure. Key samples, reads and flushes may follow
// each other in every cycle. The per-key counters live in a memory with one
// read port and one write port. It is read when a request is accepted and
// written back from the input stage, and the latest write is bypassed to the
// next request. The key buffer holds FIFO_DEPTH-1 codes and drops new ones
// when full.
module key_matrix_repeat_buffer_top
	import kmrb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res
);

	logic [7:0]       first_delay_q;
	logic [7:0]       next_delay_q;
	logic [7:0]       rel_hold_q;
	logic             s1_valid_q;
	cmd_t             cmd_s1;
	logic             res_valid_q;
	res_t             res_q;
	logic [5:0]       fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic             caps_q;
	logic             ins_q;
	logic             shl_q;

	logic             cmd_acc;
	logic             s1_adv;
	cnt_rd_t          cnt;
	mod_held_t        held;
	cnt_wr_t          wr;
	logic [5:0]       code_s1;
	logic             in_range;
	logic [PTR_W-1:0] nxt_wp;
	logic [PTR_W-1:0] nxt_rp;
	logic [7:0]       prs_n;
	logic [7:0]       rel_n;
	logic             wr_en;
	logic             queue;
	logic             push;
	logic             pop;
	logic             caps_n;
	logic             ins_n;
	logic             shl_n;
	logic [PTR_W-1:0] wp_n;
	logic [PTR_W-1:0] rp_n;
	logic [5:0]       pop_code;
	res_t             res_n;

	// handshake
	assign s1_adv    = s1_valid_q && (!res_valid_q || !res_stall);
	assign cmd_stall = s1_valid_q && !s1_adv;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q <= FIRST_DELAY_RST;
			next_delay_q  <= NEXT_DELAY_RST;
			rel_hold_q    <= REL_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIRST_DELAY: first_delay_q <= cfg_data;
				CFG_NEXT_DELAY:  next_delay_q  <= cfg_data;
				CFG_REL_HOLD:    rel_hold_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_s1 <= cmd;
		end
	end

	// per-key counters
	kmrb_count_mem u_count_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (cmd_acc),
		.rd_idx (cmd.key_index[KEY_W-1:0]),
		.wr     (wr),
		.cnt    (cnt),
		.held   (held)
	);

	assign code_s1  = cmd_s1.key_index + 6'd1;
	assign in_range = {1'b0, cmd_s1.key_index} < 7'(NUM_KEYS);
	assign nxt_wp   = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign nxt_rp   = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	// key update, buffer and flag logic for one request
	always_comb begin
		prs_n  = cnt.prs;
		rel_n  = cnt.rel;
		wr_en  = 1'b0;
		queue  = 1'b0;
		push   = 1'b0;
		pop    = 1'b0;
		caps_n = caps_q;
		ins_n  = ins_q;
		shl_n  = shl_q;
		wp_n   = wp_q;
		rp_n   = rp_q;
		case (mode_t'(cmd_s1.mode))
			MODE_SAMPLE: begin
				if (in_range) begin
					wr_en = 1'b1;
					if (cmd_s1.pressed) begin
						if (cnt.prs == 8'd0) begin
							queue = 1'b1;
							prs_n = first_delay_q;
						end else if (cmd_s1.elapsed < cnt.prs) begin
							prs_n = cnt.prs - cmd_s1.elapsed;
						end else begin
							queue = (code_s1 != CODE_SHIFT) && (code_s1 != CODE_CTRL);
							prs_n = next_delay_q;
						end
						rel_n = rel_hold_q;
					end else if (cmd_s1.elapsed < cnt.rel) begin
						rel_n = cnt.rel - cmd_s1.elapsed;
					end else begin
						rel_n = 8'd0;
						if (cnt.prs != 8'd0) begin
							prs_n = 8'd0;
							// shift tapped alone toggles caps lock
							if (code_s1 == CODE_SHIFT && shl_q) begin
								caps_n = !caps_q;
								shl_n  = 1'b0;
							end
						end
					end
				end
			end
			MODE_READ: begin
				if (rp_q != wp_q) begin
					pop  = 1'b1;
					rp_n = nxt_rp;
				end
			end
			MODE_FLUSH: begin
				rp_n = wp_q;
			end
			default: ;
		endcase
		// queue a code, dropped when the buffer is full
		if (queue) begin
			if (nxt_wp != rp_q) begin
				push = 1'b1;
				wp_n = nxt_wp;
			end
			shl_n = (code_s1 == CODE_SHIFT);
			if (code_s1 == CODE_SPACE && held.shift) begin
				ins_n = !ins_q;
			end
		end
	end

	assign wr.en  = wr_en && s1_adv;
	assign wr.idx = cmd_s1.key_index[KEY_W-1:0];
	assign wr.prs = prs_n;
	assign wr.rel = rel_n;

	// popped code and its character
	assign pop_code          = fifo_q[rp_q];
	assign res_n.key_valid   = pop;
	assign res_n.key_code    = pop ? pop_code : 6'd0;
	assign res_n.ascii_char  = pop ? kmrb_ascii(pop_code, held.shift, held.ctrl, caps_q) : 7'd0;
	assign res_n.caps_lock   = caps_n;
	assign res_n.insert_mode = ins_n;

	// key buffer storage
	always_ff @(posedge clk) begin
		if (s1_adv && push) begin
			fifo_q[wp_q] <= code_s1;
		end
	end

	// buffer pointers and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			caps_q <= 1'b0;
			ins_q  <= 1'b0;
			shl_q  <= 1'b0;
		end else if (s1_adv) begin
			wp_q   <= wp_n;
			rp_q   <= rp_n;
			caps_q <= caps_n;
			ins_q  <= ins_n;
			shl_q  <= shl_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_n;
		end
	end

`ifndef SYNTHESIS
	// request side only holds off while a result waits downstream
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (s1_valid_q && res_valid_q && res_stall))
		else $error("request stalled without a waiting result");

	// a flush leaves the buffer empty
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && cmd_s1.mode == MODE_FLUSH) |=> (rp_q == wp_q))
		else $error("buffer not empty after flush");

	// no key means no code and no character
	a_no_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.key_valid) |-> (res_q.key_code == 6'd0 && res_q.ascii_char == 7'd0))
		else $error("code or character without a key");

	// pointers stay inside the buffer
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(7'(wp_q) < 7'(FIFO_DEPTH)) && (7'(rp_q) < 7'(FIFO_DEPTH)))
		else $error("buffer pointer out of range");
`endif

endmodule

>>> sim/kmrb_result_check.sv
// request and result monitor with predictor for the key matrix repeat buffer
module kmrb_result_check
	import kmrb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 cmd_valid,
	input  logic                 cmd_stall,
	input  cmd_t                 cmd,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  res_t                 res,
	output int                   failures,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// character maps, unshifted and shifted
	localparam logic [6:0] PLAIN_CHARS [TABLE_KEYS] = '{
		7'h32, 7'h31, 7'h00, 7'h73, 7'h00, 7'h20, 7'h09, 7'h71, 7'h33, 7'h78,
		7'h65, 7'h61, 7'h7a, 7'h77, 7'h34, 7'h35, 7'h76, 7'h66, 7'h64, 7'h63,
		7'h72, 7'h36, 7'h37, 7'h6e, 7'h74, 7'h67, 7'h62, 7'h79, 7'h39, 7'h38,
		7'h68, 7'h75, 7'h6a, 7'h6d, 7'h69, 7'h5c, 7'h3d, 7'h1e, 7'h6c, 7'h3b,
		7'h1f, 7'h5b, 7'h2d, 7'h30, 7'h2c, 7'h6f, 7'h6b, 7'h2e, 7'h70, 7'h5d,
		7'h08, 7'h1d, 7'h2f, 7'h0d, 7'h1c, 7'h27
	};

	localparam logic [6:0] SHIFTED_CHARS [TABLE_KEYS] = '{
		7'h40, 7'h21, 7'h00, 7'h73, 7'h00, 7'h14, 7'h09, 7'h71, 7'h23, 7'h78,
		7'h65, 7'h61, 7'h7a, 7'h77, 7'h24, 7'h25, 7'h76, 7'h66, 7'h64, 7'h63,
		7'h72, 7'h5e, 7'h26, 7'h6e, 7'h74, 7'h67, 7'h62, 7'h79, 7'h28, 7'h2a,
		7'h68, 7'h75, 7'h6a, 7'h6d, 7'h69, 7'h7c, 7'h2b, 7'h15, 7'h6c, 7'h3a,
		7'h0c, 7'h7b, 7'h5f, 7'h29, 7'h3c, 7'h6f, 7'h6b, 7'h3e, 7'h70, 7'h7d,
		7'h7f, 7'h0b, 7'h3f, 7'h1b, 7'h04, 7'h22
	};

	// predicted block state
	logic [7:0]       first_dly, next_dly, rel_hold;
	logic [7:0]       prs_cnt [NUM_KEYS];
	logic [7:0]       rel_cnt [NUM_KEYS];
	logic [5:0]       code_buf [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr, rd_ptr;
	bit               caps_on, insert_on, shift_queued;
	res_t             pending_results [$];

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
		return PTR_W'((int'(ptr) + 1) % FIFO_DEPTH);
	endfunction

	function automatic bit key_down(input logic [5:0] code);
		return code >= 6'd1 && int'(code) <= NUM_KEYS && prs_cnt[code - 6'd1] != 8'd0;
	endfunction

	// push a code into the key buffer, dropped when full
	task automatic enqueue_code(input logic [5:0] code);
		logic [PTR_W-1:0] nxt;
		nxt = next_slot(wr_ptr);
		if (nxt != rd_ptr) begin
			code_buf[wr_ptr] = code;
			wr_ptr = nxt;
		end
		shift_queued = (code == CODE_SHIFT);
		if (code == CODE_SPACE && key_down(CODE_SHIFT)) begin
			insert_on = !insert_on;
		end
	endtask

	// character of a popped code under current shift, ctrl and caps
	function automatic logic [6:0] char_of(input logic [5:0] code);
		bit         up;
		logic [6:0] ch;
		if (code == 6'd0 || int'(code) > NUM_KEYS || int'(code) > TABLE_KEYS) begin
			return 7'd0;
		end
		up = key_down(CODE_SHIFT);
		ch = up ? SHIFTED_CHARS[code - 6'd1] : PLAIN_CHARS[code - 6'd1];
		if (ch == 7'd0) begin
			return 7'd0;
		end
		if (key_down(CODE_CTRL) && ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
			return ch & CTRL_MASK;
		end
		if (caps_on) begin
			up = !up;
		end
		if (up && ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
			ch = ch - CASE_OFFSET;
		end
		return ch;
	endfunction

	// update predicted state for one request and record its result
	task automatic apply_request(input cmd_t c);
		res_t       r;
		int         b, h, t;
		logic [5:0] code;
		r = '0;
		case (mode_t'(c.mode))
			MODE_SAMPLE: begin
				if (int'(c.key_index) < NUM_KEYS) begin
					code = c.key_index + 6'd1;
					b = prs_cnt[c.key_index];
					h = rel_cnt[c.key_index];
					t = c.elapsed;
					if (c.pressed) begin
						if (b == 0) begin
							enqueue_code(code);
							b = first_dly;
						end else if (t < b) begin
							b = b - t;
						end else begin
							if (code != CODE_SHIFT && code != CODE_CTRL) begin
								enqueue_code(code);
							end
							b = next_dly;
						end
						h = rel_hold;
					end else if (t < h) begin
						h = h - t;
					end else begin
						h = 0;
						if (b > 0) begin
							b = 0;
							// shift tapped alone flips caps lock
							if (code == CODE_SHIFT && shift_queued) begin
								caps_on = !caps_on;
								shift_queued = 1'b0;
							end
						end
					end
					prs_cnt[c.key_index] = 8'(b);
					rel_cnt[c.key_index] = 8'(h);
				end
			end
			MODE_READ: begin
				if (rd_ptr != wr_ptr) begin
					r.key_code = code_buf[rd_ptr];
					rd_ptr = next_slot(rd_ptr);
					r.key_valid = 1'b1;
					r.ascii_char = char_of(r.key_code);
				end
			end
			MODE_FLUSH: begin
				rd_ptr = wr_ptr;
			end
			default: begin
			end
		endcase
		r.caps_lock = caps_on;
		r.insert_mode = insert_on;
		pending_results.push_back(r);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			failures++;
		end
	endtask

	// watch the channels at every rising edge
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			first_dly = FIRST_DELAY_RST;
			next_dly = NEXT_DELAY_RST;
			rel_hold = REL_HOLD_RST;
			for (int i = 0; i < NUM_KEYS; i++) begin
				prs_cnt[i] = 8'd0;
				rel_cnt[i] = 8'd0;
			end
			for (int i = 0; i < FIFO_DEPTH; i++) begin
				code_buf[i] = 6'd0;
			end
			wr_ptr = '0;
			rd_ptr = '0;
			caps_on = 1'b0;
			insert_on = 1'b0;
			shift_queued = 1'b0;
			pending_results.delete();
			failures = 0;
		end else begin
			// compare an accepted result with the oldest prediction
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with no request outstanding, actual %h", $time, res);
					failures++;
				end else begin
					want = pending_results.pop_front();
					check_field("key_valid", want.key_valid, res.key_valid);
					check_field("key_code", want.key_code, res.key_code);
					check_field("ascii_char", want.ascii_char, res.ascii_char);
					check_field("caps_lock", want.caps_lock, res.caps_lock);
					check_field("insert_mode", want.insert_mode, res.insert_mode);
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FIRST_DELAY: first_dly = cfg_data;
					CFG_NEXT_DELAY:  next_dly = cfg_data;
					CFG_REL_HOLD:    rel_hold = cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				apply_request(cmd);
			end
		end
		pending = pending_results.size();
	end

endmodule

>>> sim/key_matrix_repeat_buffer_top_tb.sv
// stimulus and verdict for the key matrix repeat buffer
module key_matrix_repeat_buffer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kmrb_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 265;
	localparam int NUM_PHASES      = 5;
	localparam int IDLE_PCT        = 17;
	// ctrl, shift, space, three letters, one digit and one control character key
	localparam int HOT_KEYS [8] = '{2, 4, 5, 11, 3, 10, 0, 51};

	// opening requests: edges of the fields, every mode and the modifier cases
	localparam cmd_t OPENING [27] = '{
		'{MODE_NONE,   6'd63, 1'b1, 8'd255},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_SAMPLE, 6'd56, 1'b1, 8'd0},
		'{MODE_SAMPLE, 6'd63, 1'b1, 8'd255},
		'{MODE_SAMPLE, 6'd11, 1'b1, 8'd0},
		'{MODE_SAMPLE, 6'd11, 1'b1, 8'd255},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_SAMPLE, 6'd4,  1'b1, 8'd0},
		'{MODE_SAMPLE, 6'd4,  1'b0, 8'd255},
		'{MODE_SAMPLE, 6'd11, 1'b0, 8'd255},
		'{MODE_SAMPLE, 6'd11, 1'b1, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_SAMPLE, 6'd4,  1'b1, 8'd0},
		'{MODE_SAMPLE, 6'd5,  1'b1, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_SAMPLE, 6'd2,  1'b1, 8'd0},
		'{MODE_SAMPLE, 6'd11, 1'b0, 8'd255},
		'{MODE_SAMPLE, 6'd11, 1'b1, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_FLUSH,  6'd0,  1'b0, 8'd0},
		'{MODE_READ,   6'd0,  1'b0, 8'd0},
		'{MODE_SAMPLE, 6'd4,  1'b0, 8'd255},
		'{MODE_SAMPLE, 6'd2,  1'b0, 8'd255}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	cfg_idx_t   cfg_index = CFG_FIRST_DELAY;
	logic [7:0] cfg_data = 8'd0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_t       cmd = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_t       res;
	int         failures;
	int         pending;
	int         cycles = 0;
	bit         quiet = 1'b0;
	bit         key_held [NUM_KEYS];

	key_matrix_repeat_buffer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	kmrb_result_check result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.failures  (failures),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side back pressure
	always @(negedge clk) begin
		res_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
	end

	// present one request and hold it until accepted
	task automatic drive_request(input cmd_t c);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do begin
			@(posedge clk);
		end while (cmd_stall);
		@(negedge clk);
	endtask

	// stop requests and wait for every result to drain
	task automatic settle();
		cmd_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic program_delays(input logic [7:0] first, input logic [7:0] next,
			input logic [7:0] hold);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST_DELAY;
		cfg_data <= first;
		@(negedge clk);
		cfg_index <= CFG_NEXT_DELAY;
		cfg_data <= next;
		@(negedge clk);
		cfg_index <= CFG_REL_HOLD;
		cfg_data <= hold;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		cmd_t c;
		int   roll;
		int   k;
		int   read_pct;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening with reset delays
		foreach (OPENING[i]) begin
			drive_request(OPENING[i]);
		end

		// random phases, each with its own delay setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			quiet = 1'b0;
			case (p)
				0: begin
					program_delays(8'd1, 8'd1, 8'd1);
					read_pct = 20;
				end
				1: begin
					program_delays(8'd255, 8'd255, 8'd255);
					read_pct = 4;
				end
				2: begin
					program_delays(8'd0, 8'd0, 8'd0);
					read_pct = 30;
				end
				3: begin
					program_delays(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
						8'($urandom_range(255, 1)));
					read_pct = 10;
					quiet = 1'b1;
				end
				default: begin
					program_delays(8'($urandom_range(40, 1)), 8'($urandom_range(20, 1)),
						8'($urandom_range(60, 1)));
					read_pct = 25;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				c = cmd_t'($urandom);
				roll = $urandom_range(99);
				if (roll < read_pct) begin
					c.mode = MODE_READ;
				end else if (roll < read_pct + 3) begin
					c.mode = MODE_FLUSH;
				end else if (roll < read_pct + 5) begin
					c.mode = MODE_NONE;
				end else begin
					// key sample: mostly hot keys with levels that persist
					c.mode = MODE_SAMPLE;
					if ($urandom_range(19) == 0) begin
						k = $urandom_range(63);
					end else begin
						k = HOT_KEYS[$urandom_range(7)];
					end
					c.key_index = 6'(k);
					if (k < NUM_KEYS) begin
						if ($urandom_range(9) == 0) begin
							key_held[k] = !key_held[k];
						end
						c.pressed = key_held[k];
					end
					case ($urandom_range(3))
						0: c.elapsed = 8'($urandom_range(15));
						1: c.elapsed = 8'd255;
						2: c.elapsed = 8'($urandom_range(80, 16));
						default: c.elapsed = 8'($urandom);
					endcase
				end
				drive_request(c);
			end
		end

		settle();
		repeat (10) @(negedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/kmrb_pkg.sv
hw/rtl/kmrb_count_mem.sv
hw/rtl/key_matrix_repeat_buffer_top.sv
sim/kmrb_result_check.sv
sim/key_matrix_repeat_buffer_top_tb.sv
